/* src/assert_macros.svh */
// Assertion macros shared by the sequencer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is asserted.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/i2cms_pkg.sv */
// Shared constants, status codes and the decode control struct of the I2C
// master sequencer. No dependencies.
`default_nettype none

package i2cms_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 8;

  // Controller control register bits
  localparam logic [7:0] CTL_ACK    = 8'h04;
  localparam logic [7:0] CTL_SI     = 8'h08;
  localparam logic [7:0] CTL_STOP   = 8'h10;
  localparam logic [7:0] CTL_START  = 8'h20;
  localparam logic [7:0] CTL_ENABLE = 8'h40;
  localparam logic [7:0] CTL_ALL    = 8'hFF;

  // Bus controller status codes
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START_SENT  = 8'h08;
  localparam logic [7:0] ST_RSTART_SENT = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK   = 8'h20;
  localparam logic [7:0] ST_TXDATA_ACK  = 8'h28;
  localparam logic [7:0] ST_TXDATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK   = 8'h48;
  localparam logic [7:0] ST_RXDATA_ACK  = 8'h50;
  localparam logic [7:0] ST_RXDATA_NACK = 8'h58;

  // Decoded actions of one status event
  typedef struct packed {
    logic [7:0] clr;
    logic [7:0] set;
    logic       tx_load;
    logic       tx_from_target;
    logic       buf_advance;
    logic       read_done;
    logic       busy_release;
    logic       cnt_dec;
    logic       cnt_zero;
  } ctl_t;

endpackage

`default_nettype wire

/* src/i2cms_decode.sv */
// Status code decoder: turns one bus status code into control actions.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_decode (
  input  wire logic [7:0]      status_code,
  input  wire logic            last_byte,
  output i2cms_pkg::ctl_t      ctl
);
  import i2cms_pkg::*;

  always_comb begin
    ctl     = '0;
    ctl.clr = CTL_SI;
    unique case (status_code)
      ST_BUS_ERROR: begin
        ctl.set          = CTL_STOP;
        ctl.busy_release = 1'b1;
      end
      ST_START_SENT: begin
        ctl.tx_load        = 1'b1;
        ctl.tx_from_target = 1'b1;
        ctl.clr            = CTL_SI | CTL_START;
        ctl.set            = CTL_ACK;
      end
      ST_RSTART_SENT: begin
        ctl.tx_load        = 1'b1;
        ctl.tx_from_target = 1'b1;
        ctl.set            = CTL_ACK;
      end
      ST_SLAW_ACK: begin
        ctl.tx_load     = 1'b1;
        ctl.buf_advance = 1'b1;
      end
      ST_SLAW_NACK, ST_TXDATA_NACK: begin
        ctl.set          = CTL_STOP | CTL_ACK;
        ctl.busy_release = 1'b1;
      end
      ST_TXDATA_ACK: begin
        if (last_byte) begin
          // last byte out (or count already spent): stop and release
          ctl.cnt_zero     = 1'b1;
          ctl.set          = CTL_STOP | CTL_ACK;
          ctl.busy_release = 1'b1;
        end else begin
          ctl.cnt_dec     = 1'b1;
          ctl.tx_load     = 1'b1;
          ctl.buf_advance = 1'b1;
          ctl.set         = CTL_ACK;
        end
      end
      ST_ARB_LOST: begin
        ctl.set = CTL_START | CTL_ACK;
      end
      ST_SLAR_ACK: begin
        ctl.set = CTL_ACK;
      end
      ST_SLAR_NACK: begin
        ctl.set          = CTL_STOP;
        ctl.busy_release = 1'b1;
      end
      ST_RXDATA_ACK, ST_RXDATA_NACK: begin
        ctl.read_done    = 1'b1;
        ctl.set          = CTL_STOP;
        ctl.busy_release = 1'b1;
      end
      default: begin
        // unknown code: only the interrupt flag is cleared
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/i2cms_sendbuf.sv */
// Send buffer: byte slots loaded on a write start (slot zero also from a received byte), plus the send index.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_sendbuf #(
  parameter int BUFFER_BYTES = i2cms_pkg::BUFFER_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire logic [15:0] mem_address,
  input  wire logic [3:0]  byte_count,
  input  wire logic [47:0] write_data,
  input  wire logic        rx_store,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        idx_clear,
  input  wire logic        idx_advance,
  output logic      [7:0]  head_byte
);
  import i2cms_pkg::*;

  localparam int IDX_W = $clog2(BUFFER_BYTES);

  logic [7:0]       buf_r [BUFFER_BYTES];
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;

  // Slot zero takes the memory address high byte on a write start, or the
  // latest received byte. Data slots past the sixth write byte load zero,
  // which the shift gives for free.
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r[0] <= mem_address[15:8];
      buf_r[1] <= mem_address[7:0];
      for (int s = 2; s < BUFFER_BYTES; s++) begin
        if (int'(byte_count) > (s - 2)) begin
          buf_r[s] <= 8'(write_data >> (8 * (s - 2)));
        end
      end
    end else if (rx_store) begin
      buf_r[0] <= rx_byte;
    end
  end

  assign head_byte = buf_r[idx_r];

  always_comb begin
    idx_nxt = idx_r;
    if (idx_clear) begin
      idx_nxt = '0;
    end else if (idx_advance) begin
      idx_nxt = (idx_r == IDX_W'(BUFFER_BYTES - 1)) ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/i2c_master_transfer_sequencer.sv */
// I2C master transfer sequencer (top level; uses i2cms_pkg, i2cms_decode,
// i2cms_sendbuf and assert_macros.svh). Each request is either a transfer
// start (func 0) or one bus status event (func 1), and every request yields
// exactly one result. A start is accepted when the bus is free and the count
// fits: a read may ask for up to BUFFER_BYTES bytes, a write for up to
// BUFFER_BYTES-2, since the two memory-address bytes go ahead of the data.
// Status events return the control bits to clear (apply first) and to set,
// an optional transmit byte, a received byte and the bus lock flag. One
// request is taken per clock while in_stall is low; a result is presented once its
// request has passed the input register and then the result register, and the
// sustained rate is one request per cycle, limited only by how fast the result
// side takes results. Reading a send-buffer slot never loaded by a write start
// returns an unspecified byte.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_transfer_sequencer #(
  parameter int BUFFER_BYTES = i2cms_pkg::BUFFER_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_device_address,
  input  wire logic [15:0] in_mem_address,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic [47:0] in_write_data,
  input  wire logic [7:0]  in_status_code,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_accepted,
  output logic      [7:0]  out_clear_bits,
  output logic      [7:0]  out_set_bits,
  output logic             out_tx_load,
  output logic      [7:0]  out_tx_byte,
  output logic             out_read_done,
  output logic      [7:0]  out_read_byte,
  output logic             out_busy_res
);
  import i2cms_pkg::*;

  // bytes_left holds up to BUFFER_BYTES (write count plus two address bytes)
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  // ---------------- input register ----------------
  logic        ir_valid_r;
  logic        ir_valid_nxt;
  logic        ir_func_r;
  logic [7:0]  ir_dev_r;
  logic [15:0] ir_maddr_r;
  logic [3:0]  ir_count_r;
  logic [47:0] ir_wdata_r;
  logic [7:0]  ir_code_r;
  logic [7:0]  ir_rx_r;

  // ---------------- sequencer state ----------------
  logic             busy_r;
  logic             busy_nxt;
  logic [7:0]       target_r;
  logic [7:0]       target_nxt;
  logic [CNT_W-1:0] bytes_left_r;
  logic [CNT_W-1:0] bytes_left_nxt;

  // ---------------- result register ----------------
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       res_accepted_r;
  logic [7:0] res_clr_r;
  logic [7:0] res_set_r;
  logic       res_txl_r;
  logic [7:0] res_txb_r;
  logic       res_rd_r;
  logic [7:0] res_rb_r;
  logic       res_busy_r;

  logic       res_accepted;
  logic [7:0] res_clr;
  logic [7:0] res_set;
  logic       res_txl;
  logic [7:0] res_txb;
  logic       res_rd;
  logic [7:0] res_rb;

  // ---------------- handshake ----------------
  logic in_take;
  logic res_free;
  logic advance;

  // The held request moves on whenever the result register is empty or
  // being emptied this cycle; the input register refills in the same cycle.
  assign res_free = !out_valid_r || !out_stall;
  assign advance  = ir_valid_r && res_free;
  assign in_stall = ir_valid_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (in_take) begin
      ir_valid_nxt = 1'b1;
    end else if (advance) begin
      ir_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ir_valid_r  <= ir_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request payload; hold it while stalled.
  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_func_r  <= in_func;
      ir_dev_r   <= in_device_address;
      ir_maddr_r <= in_mem_address;
      ir_count_r <= in_byte_count;
      ir_wdata_r <= in_write_data;
      ir_code_r  <= in_status_code;
      ir_rx_r    <= in_rx_byte;
    end
  end

  // ---------------- start checks ----------------
  logic is_status;
  logic is_read;
  logic too_long;
  logic start_ok;

  assign is_status = ir_func_r;
  assign is_read   = ir_dev_r[0];
  // Reads fill the whole buffer; writes lose two slots to the address bytes.
  assign too_long  = is_read ? (int'(ir_count_r) > BUFFER_BYTES)
                             : ((int'(ir_count_r) + 2) > BUFFER_BYTES);
  assign start_ok  = !is_status && !too_long && !busy_r;

  // ---------------- status decode ----------------
  ctl_t ctl;
  logic last_byte;

  assign last_byte = (bytes_left_r <= CNT_W'(1));

  i2cms_decode u_decode (
    .status_code (ir_code_r),
    .last_byte   (last_byte),
    .ctl         (ctl)
  );

  // ---------------- send buffer ----------------
  logic [7:0] head_byte;

  i2cms_sendbuf #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_sendbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (advance && start_ok && !is_read),
    .mem_address (ir_maddr_r),
    .byte_count  (ir_count_r),
    .write_data  (ir_wdata_r),
    .rx_store    (advance && is_status && ctl.read_done),
    .rx_byte     (ir_rx_r),
    .idx_clear   (advance && start_ok),
    .idx_advance (advance && is_status && ctl.buf_advance),
    .head_byte   (head_byte)
  );

  // ---------------- step logic ----------------
  always_comb begin
    busy_nxt       = busy_r;
    target_nxt     = target_r;
    bytes_left_nxt = bytes_left_r;
    res_accepted   = 1'b0;
    res_clr        = 8'h00;
    res_set        = 8'h00;
    res_txl        = 1'b0;
    res_txb        = 8'h00;
    res_rd         = 1'b0;
    res_rb         = 8'h00;
    if (is_status) begin
      res_accepted = 1'b1;
      res_clr      = ctl.clr;
      res_set      = ctl.set;
      res_txl      = ctl.tx_load;
      if (ctl.tx_load) begin
        res_txb = ctl.tx_from_target ? target_r : head_byte;
      end
      res_rd = ctl.read_done;
      if (ctl.read_done) begin
        res_rb = ir_rx_r;
      end
      if (ctl.busy_release) begin
        busy_nxt = 1'b0;
      end
      // Count never wraps: a spent count stays at zero.
      if (ctl.cnt_zero) begin
        bytes_left_nxt = '0;
      end else if (ctl.cnt_dec) begin
        bytes_left_nxt = bytes_left_r - 1'b1;
      end
    end else if (start_ok) begin
      res_accepted = 1'b1;
      res_clr      = CTL_ALL;
      res_set      = CTL_ENABLE | CTL_START;
      busy_nxt     = 1'b1;
      target_nxt   = ir_dev_r;
      if (is_read) begin
        bytes_left_nxt = CNT_W'(ir_count_r);
      end else begin
        bytes_left_nxt = CNT_W'(5'({1'b0, ir_count_r}) + 5'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      target_r     <= 8'h00;
      bytes_left_r <= '0;
    end else if (advance) begin
      busy_r       <= busy_nxt;
      target_r     <= target_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // Result payload: load on advance, hold while the result side stalls.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_accepted_r <= res_accepted;
      res_clr_r      <= res_clr;
      res_set_r      <= res_set;
      res_txl_r      <= res_txl;
      res_txb_r      <= res_txb;
      res_rd_r       <= res_rd;
      res_rb_r       <= res_rb;
      res_busy_r     <= busy_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = res_accepted_r;
  assign out_clear_bits = res_clr_r;
  assign out_set_bits   = res_set_r;
  assign out_tx_load    = res_txl_r;
  assign out_tx_byte    = res_txb_r;
  assign out_read_done  = res_rd_r;
  assign out_read_byte  = res_rb_r;
  assign out_busy_res   = res_busy_r;

  // ---------------- assertions ----------------
  `ASSERT_CLKD(a_no_tx_and_rx,
               (out_valid |-> !(out_tx_load && out_read_done)),
               "tx and rx in one result")
  `ASSERT_CLKD(a_reject_quiet,
               (out_valid && !out_accepted |-> out_set_bits == 8'h00 && out_clear_bits == 8'h00),
               "rejected start drives control bits")
  `ASSERT_CLKD(a_start_locks,
               (out_valid && out_clear_bits == CTL_ALL |-> out_busy_res),
               "accepted start left bus unlocked")
  `ASSERT_ALWAYS(a_count_range,
                 (!rst_n || bytes_left_r <= CNT_W'(BUFFER_BYTES)),
                 "byte count beyond buffer size")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master transfer sequencer: a directed table, then
// randomized write and read transfers with noise, checked against a predictor in the bench.
// Depends on i2cms_pkg and the i2c_master_transfer_sequencer RTL only.
module testbench;
  import i2cms_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int SLOTS        = BUFFER_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS = 500;
  // Status code that the controller never reports; must decode to "clear SI only".
  localparam logic [7:0] ST_UNKNOWN = 8'hFF;

  typedef enum bit {FN_START = 1'b0, FN_STATUS = 1'b1} func_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  device_address;
    logic [15:0] mem_address;
    logic [3:0]  byte_count;
    logic [47:0] write_data;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
  } xfer_req_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] clear_bits;
    logic [7:0] set_bits;
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       read_done;
    logic [7:0] read_byte;
    logic       busy_res;
  } bus_action_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    xfer_req_t   rq;
    bit          typed;
    bus_action_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [7:0]  in_device_address = 8'h00;
  logic [15:0] in_mem_address = 16'h0000;
  logic [3:0]  in_byte_count = 4'h0;
  logic [47:0] in_write_data = 48'h0;
  logic [7:0]  in_status_code = 8'h00;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [7:0]  out_clear_bits;
  logic [7:0]  out_set_bits;
  logic        out_tx_load;
  logic [7:0]  out_tx_byte;
  logic        out_read_done;
  logic [7:0]  out_read_byte;
  logic        out_busy_res;

  i2c_master_transfer_sequencer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_device_address (in_device_address),
    .in_mem_address    (in_mem_address),
    .in_byte_count     (in_byte_count),
    .in_write_data     (in_write_data),
    .in_status_code    (in_status_code),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_clear_bits    (out_clear_bits),
    .out_set_bits      (out_set_bits),
    .out_tx_load       (out_tx_load),
    .out_tx_byte       (out_tx_byte),
    .out_read_done     (out_read_done),
    .out_read_byte     (out_read_byte),
    .out_busy_res      (out_busy_res)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: bus lock, addressed device, bytes still to send, the send buffer,
  // which of its slots hold data, and the transmit pointer.
  logic       lock_q;
  logic [7:0] target_q;
  logic [3:0] left_q;
  logic [7:0] slot_q [SLOTS];
  bit         slot_loaded [SLOTS];
  int         tx_ptr;

  bus_action_t pending_actions [$];
  xfer_req_t   plan_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          in_burst_left = 0;

  function automatic xfer_req_t start_req(logic [7:0] dev, logic [15:0] maddr,
                                          logic [3:0] cnt, logic [47:0] wdata);
    xfer_req_t rq;
    rq = '0;
    rq.func           = FN_START;
    rq.device_address = dev;
    rq.mem_address    = maddr;
    rq.byte_count     = cnt;
    rq.write_data     = wdata;
    return rq;
  endfunction

  function automatic xfer_req_t status_req(logic [7:0] code, logic [7:0] rx);
    xfer_req_t rq;
    rq = '0;
    rq.func        = FN_STATUS;
    rq.status_code = code;
    rq.rx_byte     = rx;
    return rq;
  endfunction

  function automatic bus_action_t mk_action(logic acc, logic [7:0] clr, logic [7:0] set,
                                            logic txl, logic [7:0] txb, logic rd,
                                            logic [7:0] rb, logic busy);
    bus_action_t a;
    a = '{acc, clr, set, txl, txb, rd, rb, busy};
    return a;
  endfunction

  // Fill every field at random; fields that the request kind ignores still toggle.
  function automatic xfer_req_t rand_req(func_e fn);
    xfer_req_t rq;
    rq.func           = fn;
    rq.device_address = 8'($urandom_range(0, 255));
    rq.mem_address    = 16'($urandom_range(0, 65535));
    rq.byte_count     = 4'($urandom_range(0, 15));
    rq.write_data     = {16'($urandom()), $urandom()};
    rq.status_code    = 8'($urandom_range(0, 255));
    rq.rx_byte        = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  function automatic xfer_req_t rand_status(logic [7:0] code);
    xfer_req_t rq;
    rq = rand_req(FN_STATUS);
    rq.status_code = code;
    return rq;
  endfunction

  // True when this request would transmit a buffer slot that no write start has loaded.
  function automatic bit hits_unloaded_slot(xfer_req_t rq);
    if (rq.func != FN_STATUS) return 1'b0;
    if (rq.status_code == ST_SLAW_ACK ||
        (rq.status_code == ST_TXDATA_ACK && left_q > 4'd1)) return !slot_loaded[tx_ptr];
    return 1'b0;
  endfunction

  task automatic next_slot_byte(output logic [7:0] b);
    b = slot_q[tx_ptr];
    tx_ptr = (tx_ptr + 1) % SLOTS;
  endtask

  // Advance the predictor by one accepted request and return the bus action it causes.
  task automatic decode_request(input xfer_req_t rq, output bus_action_t act);
    bit is_read;
    bit too_long;
    int i;
    act = '0;
    if (rq.func == FN_START) begin
      is_read  = rq.device_address[0];
      too_long = is_read ? (int'(rq.byte_count) > SLOTS) : (int'(rq.byte_count) + 2 > SLOTS);
      if (!too_long && !lock_q) begin
        act.accepted = 1'b1;
        lock_q   = 1'b1;
        target_q = rq.device_address;
        tx_ptr   = 0;
        if (is_read) begin
          left_q = rq.byte_count;
        end else begin
          // memory address goes out high byte first, then the data bytes
          left_q = rq.byte_count + 4'd2;
          slot_q[0] = rq.mem_address[15:8];
          slot_q[1] = rq.mem_address[7:0];
          slot_loaded[0] = 1'b1;
          slot_loaded[1] = 1'b1;
          for (i = 0; i < int'(rq.byte_count) && i + 2 < SLOTS; i++) begin
            slot_q[i + 2] = (i < 6) ? rq.write_data[8 * i +: 8] : 8'h00;
            slot_loaded[i + 2] = 1'b1;
          end
        end
        act.clear_bits = CTL_ALL;
        act.set_bits   = CTL_ENABLE | CTL_START;
      end
    end else begin
      act.accepted   = 1'b1;
      act.clear_bits = CTL_SI;
      case (rq.status_code)
        ST_BUS_ERROR: begin
          act.set_bits = CTL_STOP;
          lock_q = 1'b0;
        end
        ST_START_SENT: begin
          act.tx_load = 1'b1;
          act.tx_byte = target_q;
          act.clear_bits = CTL_SI | CTL_START;
          act.set_bits = CTL_ACK;
        end
        ST_RSTART_SENT: begin
          act.tx_load = 1'b1;
          act.tx_byte = target_q;
          act.set_bits = CTL_ACK;
        end
        ST_SLAW_ACK: begin
          act.tx_load = 1'b1;
          next_slot_byte(act.tx_byte);
        end
        ST_SLAW_NACK, ST_TXDATA_NACK: begin
          act.set_bits = CTL_STOP | CTL_ACK;
          lock_q = 1'b0;
        end
        ST_TXDATA_ACK: begin
          // last byte out (or nothing left at all): stop and hold the count at zero
          if (left_q <= 4'd1) begin
            left_q = 4'd0;
            act.set_bits = CTL_STOP | CTL_ACK;
            lock_q = 1'b0;
          end else begin
            left_q = left_q - 4'd1;
            act.tx_load = 1'b1;
            next_slot_byte(act.tx_byte);
            act.set_bits = CTL_ACK;
          end
        end
        ST_ARB_LOST:  act.set_bits = CTL_START | CTL_ACK;
        ST_SLAR_ACK:  act.set_bits = CTL_ACK;
        ST_SLAR_NACK: begin
          act.set_bits = CTL_STOP;
          lock_q = 1'b0;
        end
        ST_RXDATA_ACK, ST_RXDATA_NACK: begin
          slot_q[0] = rq.rx_byte;
          slot_loaded[0] = 1'b1;
          act.read_done = 1'b1;
          act.read_byte = rq.rx_byte;
          act.set_bits = CTL_STOP;
          lock_q = 1'b0;
        end
        default: ;
      endcase
    end
    act.busy_res = lock_q;
  endtask

  // Queue one random bus transaction: mostly well-formed writes and reads with random
  // content, sometimes broken off by a NACK or lost arbitration, plus some noise.
  task automatic plan_transfer();
    xfer_req_t rq;
    int kind;
    int cnt;
    int n;
    int k;
    int r;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS - 1, 15)
                                        : $urandom_range(0, SLOTS - 2);
      rq = rand_req(FN_START);
      rq.device_address[0] = 1'b0;
      rq.byte_count = 4'(cnt);
      plan_q.push_back(rq);
      plan_q.push_back(rand_status(($urandom_range(0, 9) == 0) ? ST_RSTART_SENT
                                                                : ST_START_SENT));
      if ($urandom_range(0, 9) == 0) begin
        plan_q.push_back(rand_status(ST_SLAW_NACK));
      end else begin
        plan_q.push_back(rand_status(ST_SLAW_ACK));
        // one data ACK per byte left plus the closing one; now and then one extra
        n = cnt + 2 + (($urandom_range(0, 4) == 0) ? 1 : 0);
        for (k = 0; k < n; k++) begin
          r = $urandom_range(0, 39);
          if (r == 0) begin
            plan_q.push_back(rand_status(ST_TXDATA_NACK));
            break;
          end
          if (r == 1) plan_q.push_back(rand_status(ST_ARB_LOST));
          plan_q.push_back(rand_status(ST_TXDATA_ACK));
        end
      end
    end else if (kind < 85) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS + 1, 15)
                                        : $urandom_range(0, SLOTS);
      rq = rand_req(FN_START);
      rq.device_address[0] = 1'b1;
      rq.byte_count = 4'(cnt);
      plan_q.push_back(rq);
      plan_q.push_back(rand_status(ST_START_SENT));
      if ($urandom_range(0, 9) == 0) begin
        plan_q.push_back(rand_status(ST_SLAR_NACK));
      end else begin
        plan_q.push_back(rand_status(ST_SLAR_ACK));
        plan_q.push_back(rand_status($urandom_range(0, 1) ? ST_RXDATA_ACK : ST_RXDATA_NACK));
      end
    end else begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        rq = rand_req(func_e'($urandom_range(0, 1)));
        // half the noise uses a defined code: all of them are multiples of eight
        if (rq.func == FN_STATUS && $urandom_range(0, 1) == 1)
          rq.status_code = 8'($urandom_range(0, 11)) << 3;
        plan_q.push_back(rq);
      end
    end
  endtask

  // Mostly back-to-back or short gaps, a few long ones, and now and then a gap-free burst.
  function automatic int pick_in_gap();
    int r;
    if (in_burst_left > 0) begin
      in_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      in_burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one request, hold it until taken, then predict its bus action.
  task automatic send_request(input xfer_req_t rq, input bit typed, input bus_action_t want);
    bus_action_t act;
    int gap;
    if (hits_unloaded_slot(rq)) rq.status_code = ST_SLAW_NACK;
    gap = pick_in_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= rq.func;
    in_device_address <= rq.device_address;
    in_mem_address    <= rq.mem_address;
    in_byte_count     <= rq.byte_count;
    in_write_data     <= rq.write_data;
    in_status_code    <= rq.status_code;
    in_rx_byte        <= rq.rx_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_request(rq, act);
    pending_actions.push_back(typed ? want : act);
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  initial begin : stimulus
    dir_row_t rows [$];
    int sent;
    lock_q   = 1'b0;
    target_q = 8'h00;
    left_q   = 4'd0;
    tx_ptr   = 0;
    foreach (slot_q[i]) begin
      slot_q[i] = 8'h00;
      slot_loaded[i] = 1'b0;
    end
    sent = 0;

    rows = '{
      // right after reset: data ACK with nothing left just stops
      '{status_req(ST_TXDATA_ACK, 8'h00), 1'b1,
        mk_action(1'b1, CTL_SI, CTL_STOP | CTL_ACK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0)},
      // unknown code: only the interrupt flag is cleared
      '{status_req(ST_UNKNOWN, 8'h00), 1'b1,
        mk_action(1'b1, CTL_SI, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0)},
      // oversize read, oversize write
      '{start_req(8'h01, 16'h0000, 4'hF, 48'h0), 1'b1, '0},
      '{start_req(8'hFE, 16'hFFFF, 4'(SLOTS - 1), '1), 1'b1, '0},
      // largest write, then a start while the bus is locked
      '{start_req(8'hA0, 16'hFFFF, 4'(SLOTS - 2), 48'h66_5544_3322_11), 1'b1,
        mk_action(1'b1, CTL_ALL, CTL_ENABLE | CTL_START, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1)},
      '{start_req(8'h00, 16'h0000, 4'd0, 48'h0), 1'b1,
        mk_action(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1)},
      '{status_req(ST_START_SENT, 8'h00), 1'b1,
        mk_action(1'b1, CTL_SI | CTL_START, CTL_ACK, 1'b1, 8'hA0, 1'b0, 8'h00, 1'b1)},
      '{status_req(ST_SLAW_ACK, 8'h00), 1'b0, '0},
      '{status_req(ST_TXDATA_ACK, 8'h00), 1'b0, '0},
      '{status_req(ST_TXDATA_ACK, 8'h00), 1'b0, '0},
      '{status_req(ST_ARB_LOST, 8'h00), 1'b0, '0},
      '{status_req(ST_TXDATA_NACK, 8'h00), 1'b0, '0},
      // largest read
      '{start_req(8'hFF, 16'h1234, 4'(SLOTS), 48'h0), 1'b1,
        mk_action(1'b1, CTL_ALL, CTL_ENABLE | CTL_START, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1)},
      '{status_req(ST_RSTART_SENT, 8'h00), 1'b0, '0},
      '{status_req(ST_SLAR_ACK, 8'h00), 1'b0, '0},
      '{status_req(ST_RXDATA_ACK, 8'h00), 1'b0, '0},
      '{status_req(ST_RXDATA_NACK, 8'hFF), 1'b0, '0},
      '{status_req(ST_BUS_ERROR, 8'h00), 1'b0, '0},
      '{status_req(ST_SLAR_NACK, 8'h00), 1'b0, '0},
      '{status_req(ST_SLAW_NACK, 8'h00), 1'b0, '0},
      // empty write: only the two address bytes go out
      '{start_req(8'h00, 16'h0000, 4'd0, 48'h0), 1'b1,
        mk_action(1'b1, CTL_ALL, CTL_ENABLE | CTL_START, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1)},
      '{status_req(ST_SLAW_ACK, 8'h00), 1'b0, '0},
      '{status_req(ST_TXDATA_ACK, 8'h00), 1'b0, '0},
      '{status_req(ST_TXDATA_ACK, 8'h00), 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].want);

    while (sent < RANDOM_ITEMS) begin
      if (plan_q.size() == 0) plan_transfer();
      send_request(plan_q.pop_front(), 1'b0, '0);
      sent++;
    end
    in_valid <= 1'b0;

    // drain, then wait for any stray result to show up
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("i2c_master_transfer_sequencer test passed");
    end else begin
      $display("i2c_master_transfer_sequencer test failed");
    end
    $finish;
  end

  // Result side: random stalls, stall-free stretches, and one long hold-off once the
  // traffic is going so the block fills up and stalls its request side.
  initial begin : result_receiver
    int stall_left;
    int steady_left;
    int hold_left;
    bit pressure_done;
    int r;
    stall_left = 0;
    steady_left = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!pressure_done && results_seen >= 150) begin
        pressure_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (steady_left > 0) begin
        steady_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          steady_left = $urandom_range(20, 60);
          out_stall <= 1'b0;
        end else if (r < 60) begin
          out_stall <= 1'b0;
        end else if (r < 93) begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(6, 25);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Compare every taken result with the oldest predicted bus action.
  always @(posedge clk) begin : result_check
    bus_action_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_actions.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %0h",
                 $time, {out_accepted, out_clear_bits, out_set_bits, out_tx_load,
                         out_tx_byte, out_read_done, out_read_byte, out_busy_res});
        mismatches++;
      end else begin
        want = pending_actions.pop_front();
        check_field("accepted",   {7'b0, want.accepted},  {7'b0, out_accepted});
        check_field("clear_bits", want.clear_bits,        out_clear_bits);
        check_field("set_bits",   want.set_bits,          out_set_bits);
        check_field("tx_load",    {7'b0, want.tx_load},   {7'b0, out_tx_load});
        check_field("tx_byte",    want.tx_byte,           out_tx_byte);
        check_field("read_done",  {7'b0, want.read_done}, {7'b0, out_read_done});
        check_field("read_byte",  want.read_byte,         out_read_byte);
        check_field("busy_res",   {7'b0, want.busy_res},  {7'b0, out_busy_res});
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  initial begin : watchdog
    #(CLK_PERIOD * 500_000);
    $display("i2c_master_transfer_sequencer test failed");
    $finish;
  end

endmodule

/* i2c_master_transfer_sequencer.f */
+incdir+src
src/i2cms_pkg.sv
src/i2cms_decode.sv
src/i2cms_sendbuf.sv
src/i2c_master_transfer_sequencer.sv
tb/testbench.sv
